/* hw/rtl/cpef_pkg.sv */
package cpef_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = COL_W + 1;          // holds MAX_WIDTH itself
    localparam int HEIGHT_CAP = 4096;
    localparam int ROW_W      = $clog2(HEIGHT_CAP);

    // Register fields
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int SHIFT_W = 3;
    localparam int THR_W   = 12;

    // Pixel data
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;
    localparam int ENTRY_W  = 2 * PIX_W;            // {upper, middle}

    // Edge sums: four neighbours per lane, lanes summed in the merge
    localparam int LANE_SUM_W = CHAN_W + 2;
    localparam int EDGE_SUM_W = LANE_SUM_W + 2;

    // Result buffer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_SHIFT    = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = CFG_INDEX_W'(4);

    localparam logic [FW_W-1:0]    RST_FRAME_WIDTH    = FW_W'(640);
    localparam logic [FH_W-1:0]    RST_FRAME_HEIGHT   = FH_W'(480);
    localparam logic               RST_COLOR_MODE     = 1'b0;
    localparam logic [SHIFT_W-1:0] RST_QUANT_SHIFT    = SHIFT_W'(5);
    localparam logic [THR_W-1:0]   RST_EDGE_THRESHOLD = THR_W'(50);

    // Item kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic valid;
        logic has_result;
        logic border;
        logic last;
    } stage_ctrl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_gray_or_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              edge_flag;
        logic              frame_last;
    } result_t;

endpackage

/* hw/rtl/cpef_ifs.sv */
interface cpef_pixel_if import cpef_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [CHAN_W-1:0] gray_or_red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, func, gray_or_red, green, blue, input ready);
    modport sink   (input valid, func, gray_or_red, green, blue, output ready);
endinterface

interface cpef_result_if import cpef_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_gray_or_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              edge_flag;
    logic              frame_last;

    modport source (output valid, out_gray_or_red, out_green, out_blue, edge_flag,
                    frame_last, input ready);
    modport sink   (input valid, out_gray_or_red, out_green, out_blue, edge_flag,
                    frame_last, output ready);
endinterface

interface cpef_cfg_if import cpef_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/cpef_ram.sv */
module cpef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hw/rtl/cpef_lane.sv */
module cpef_lane import cpef_pkg::*; (
    input  logic                  clk,
    input  logic [CHAN_W-1:0]     center,
    input  logic [CHAN_W-1:0]     above,
    input  logic [CHAN_W-1:0]     below,
    input  logic [CHAN_W-1:0]     left,
    input  logic [CHAN_W-1:0]     right,
    output logic [LANE_SUM_W-1:0] sum_reg
);

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [LANE_SUM_W-1:0] sum_next;

    assign sum_next = LANE_SUM_W'(absdiff(center, above))
                    + LANE_SUM_W'(absdiff(center, below))
                    + LANE_SUM_W'(absdiff(center, left))
                    + LANE_SUM_W'(absdiff(center, right));

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

endmodule

/* hw/rtl/cpef_merge.sv */
module cpef_merge import cpef_pkg::*; (
    input  stage_ctrl_t                          ctrl,
    input  logic [PIX_W-1:0]                     center,
    input  logic [NUM_CHAN-1:0][LANE_SUM_W-1:0]  lane_sum,
    input  logic                                 color_mode,
    input  logic [SHIFT_W-1:0]                   quant_shift,
    input  logic [THR_W-1:0]                     edge_threshold,
    output logic                                 push,
    output result_t                              item
);

    logic [EDGE_SUM_W-1:0]          edge_sum;
    logic                           is_edge;
    logic [CHAN_W-1:0]              mask;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_out;

    // channel 0 always counts; the others only in colour mode
    always_comb
    begin
        edge_sum = EDGE_SUM_W'(lane_sum[0]);
        for (int k = 1; k < NUM_CHAN; k++)
        begin
            if (color_mode)
            begin
                edge_sum = edge_sum + EDGE_SUM_W'(lane_sum[k]);
            end
        end
    end

    assign is_edge = !ctrl.border && (EDGE_SUM_W'(edge_threshold) < edge_sum);
    assign mask    = {CHAN_W{1'b1}} << quant_shift;

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (is_edge || (k != 0 && !color_mode))
            begin
                chan_out[k] = '0;
            end
            else
            begin
                chan_out[k] = center[k*CHAN_W +: CHAN_W] & mask;
            end
        end
    end

    assign push                 = ctrl.valid && ctrl.has_result;
    assign item.out_gray_or_red = chan_out[0];
    assign item.out_green       = chan_out[1];
    assign item.out_blue        = chan_out[2];
    assign item.edge_flag       = is_edge;
    assign item.frame_last      = ctrl.last;

endmodule

/* hw/rtl/cpef_out_buf.sv */
module cpef_out_buf import cpef_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               push_item,
    cpef_result_if.source         result,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    pop;
    result_t                 head;

    assign pop  = result.valid && result.ready;
    assign head = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign count                  = count_reg;
    assign result.valid           = (count_reg != '0);
    assign result.out_gray_or_red = head.out_gray_or_red;
    assign result.out_green       = head.out_green;
    assign result.out_blue        = head.out_blue;
    assign result.edge_flag       = head.edge_flag;
    assign result.frame_last      = head.frame_last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result buffer written while full");
`endif

endmodule

/* hw/rtl/cartoon_posterize_edge_filter.sv */
// Cartoon filter: pixels come in raster order and each beat on the pixel
// channel is one pixel (func = pixel) or one drain beat (func = drain).
// Each output pixel is its row-above position in the stream: the pixel beat
// at (r, c) yields pixel (r-1, c), so row 0 yields nothing and the last row
// of a frame comes out on drain beats, frame_last marking its final pixel.
// An interior pixel whose summed absolute difference to its four
// neighbours (channel 0 in gray mode, all three in colour mode) exceeds
// edge_threshold comes out black with edge_flag set; everything else has its
// low quant_shift bits cleared. Border pixels never count as edges. In gray
// mode out_green and out_blue are zero. Throughput is one beat per clock,
// stalls aside; each result passes stage 1, stage 2 and the result buffer.
// The two line stores live in one dual-read RAM of {upper, middle} entries:
// each pixel reads its column and the next one, and writes its column
// from stage 1, with a one-deep bypass for the read-during-write case. Three
// channel lanes form the neighbour sums and a merge stage adds them,
// thresholds and posterizes. A four-deep result buffer decouples the result
// side, and the pixel side is held off once the buffer and the two pipeline
// stages together hold four beats. Register writes
// are accepted at any time (ready is tied high) but are meant for idle
// periods; any write to indices 0 to 4 restarts the frame position. Widths of 0 or
// heights of 0 act as 1; widths above 1024 act as 1024.
module cartoon_posterize_edge_filter import cpef_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    cpef_pixel_if.sink    pixel,
    cpef_result_if.source result,
    cpef_cfg_if.sink      cfg
);

    // Configuration
    logic [FW_W-1:0]    frame_width_reg;
    logic [FH_W-1:0]    frame_height_reg;
    logic               color_mode_reg;
    logic [SHIFT_W-1:0] quant_shift_reg;
    logic [THR_W-1:0]   edge_threshold_reg;

    // Frame position
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [EW_W-1:0]    pending_reg;

    // Accept-side decode
    logic [EW_W-1:0]    eff_w;
    logic [FH_W-1:0]    eff_h;
    logic               accept;
    logic               is_pixel;
    logic               last_col;
    logic               last_row;
    logic               pending_nz;
    logic [COL_W-1:0]   drain_idx;
    logic [COL_W-1:0]   raddr_a;
    logic [COL_W-1:0]   raddr_b;
    logic               cfg_hit;
    stage_ctrl_t        s1_ctrl_next;

    // Stage 1: line-store data back
    stage_ctrl_t        s1_ctrl_reg;
    logic               s1_write_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [ENTRY_W-1:0] ram_a;
    logic [ENTRY_W-1:0] ram_b;
    logic               fwd_a_reg;
    logic               fwd_b_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [ENTRY_W-1:0] entry_a;
    logic [ENTRY_W-1:0] entry_b;
    logic [PIX_W-1:0]   center;
    logic [PIX_W-1:0]   above;
    logic [PIX_W-1:0]   right;
    logic [PIX_W-1:0]   left_reg;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;

    // Stage 2: merge
    stage_ctrl_t                         s2_ctrl_reg;
    logic [PIX_W-1:0]                    s2_center_reg;
    logic [NUM_CHAN-1:0][LANE_SUM_W-1:0] lane_sum;
    logic                                push;
    result_t                             push_item;
    logic [FIFO_CNT_W-1:0]               buf_count;
    logic [FIFO_CNT_W-1:0]               occupancy;

    // ---------------------------------------------------------------
    // Effective frame size
    // ---------------------------------------------------------------
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            eff_h = FH_W'(1);
        end
        else if (int'(frame_height_reg) > HEIGHT_CAP)
        begin
            eff_h = FH_W'(HEIGHT_CAP);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
    end

    // ---------------------------------------------------------------
    // Accept and position decode
    // ---------------------------------------------------------------
    // Space for a beat: every item in stage 1 or 2 may still need a slot.
    assign occupancy   = buf_count + FIFO_CNT_W'(s1_ctrl_reg.valid)
                                   + FIFO_CNT_W'(s2_ctrl_reg.valid);
    assign pixel.ready = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept      = pixel.valid && pixel.ready;
    assign is_pixel    = (pixel.func == FUNC_PIXEL);

    assign last_col   = ((EW_W'(col_reg) + EW_W'(1)) >= eff_w);
    assign last_row   = ((FH_W'(row_reg) + FH_W'(1)) >= eff_h);
    assign pending_nz = (pending_reg != '0);
    // drains walk the stored last row from column 0
    assign drain_idx  = COL_W'(eff_w - pending_reg);

    assign raddr_a = is_pixel ? col_reg : drain_idx;
    assign raddr_b = col_reg + COL_W'(1);

    always_comb
    begin
        s1_ctrl_next.valid = accept;
        if (is_pixel)
        begin
            s1_ctrl_next.has_result = (row_reg != '0);
            s1_ctrl_next.border     = (row_reg == ROW_W'(1)) || (col_reg == '0) || last_col;
            s1_ctrl_next.last       = 1'b0;
        end
        else
        begin
            s1_ctrl_next.has_result = pending_nz;
            s1_ctrl_next.border     = 1'b1;
            s1_ctrl_next.last       = (pending_reg == EW_W'(1));
        end
    end

    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid && (cfg.index <= REG_EDGE_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            color_mode_reg     <= RST_COLOR_MODE;
            quant_shift_reg    <= RST_QUANT_SHIFT;
            edge_threshold_reg <= RST_EDGE_THRESHOLD;
            col_reg            <= '0;
            row_reg            <= '0;
            pending_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (is_pixel)
                begin
                    // a pixel drops any unflushed last row
                    pending_reg <= '0;
                    if (last_col)
                    begin
                        col_reg <= '0;
                        if (last_row)
                        begin
                            row_reg     <= '0;
                            pending_reg <= eff_w;
                        end
                        else
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                else if (pending_nz)
                begin
                    pending_reg <= pending_reg - EW_W'(1);
                end
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_FRAME_WIDTH:    frame_width_reg    <= cfg.data[FW_W-1:0];
                    REG_FRAME_HEIGHT:   frame_height_reg   <= cfg.data[FH_W-1:0];
                    REG_COLOR_MODE:     color_mode_reg     <= cfg.data[0];
                    REG_QUANT_SHIFT:    quant_shift_reg    <= cfg.data[SHIFT_W-1:0];
                    REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg.data[THR_W-1:0];
                    default:            ;
                endcase
            end

            if (cfg_hit)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                pending_reg <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Line store: entry = {upper, middle}
    // ---------------------------------------------------------------
    cpef_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s1_col_reg),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // Bypass the write that lands on the same edge as the read.
    assign entry_a = fwd_a_reg ? fwd_data_reg : ram_a;
    assign entry_b = fwd_b_reg ? fwd_data_reg : ram_b;
    assign center  = entry_a[PIX_W-1:0];
    assign above   = entry_a[ENTRY_W-1:PIX_W];
    assign right   = entry_b[PIX_W-1:0];

    // middle moves up, the new pixel becomes middle
    assign ram_we    = s1_ctrl_reg.valid && s1_write_reg;
    assign ram_wdata = {center, s1_pix_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg  <= '0;
            s1_write_reg <= 1'b0;
            s2_ctrl_reg  <= '0;
        end
        else
        begin
            s1_ctrl_reg  <= s1_ctrl_next;
            s1_write_reg <= is_pixel;
            s2_ctrl_reg  <= s1_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg    <= col_reg;
        s1_pix_reg    <= {pixel.blue, pixel.green, pixel.gray_or_red};
        fwd_a_reg     <= ram_we && (s1_col_reg == raddr_a);
        fwd_b_reg     <= ram_we && (s1_col_reg == raddr_b);
        fwd_data_reg  <= ram_wdata;
        s2_center_reg <= center;
        if (ram_we)
        begin
            left_reg <= center;
        end
    end

    // ---------------------------------------------------------------
    // Channel lanes and merge
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_CHAN; k++)
    begin : g_lane
        cpef_lane u_lane (
            .clk     (clk),
            .center  (center[k*CHAN_W +: CHAN_W]),
            .above   (above[k*CHAN_W +: CHAN_W]),
            .below   (s1_pix_reg[k*CHAN_W +: CHAN_W]),
            .left    (left_reg[k*CHAN_W +: CHAN_W]),
            .right   (right[k*CHAN_W +: CHAN_W]),
            .sum_reg (lane_sum[k])
        );
    end

    cpef_merge u_merge (
        .ctrl           (s2_ctrl_reg),
        .center         (s2_center_reg),
        .lane_sum       (lane_sum),
        .color_mode     (color_mode_reg),
        .quant_shift    (quant_shift_reg),
        .edge_threshold (edge_threshold_reg),
        .push           (push),
        .item           (push_item)
    );

    cpef_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .result    (result),
        .count     (buf_count)
    );

`ifndef SYNTHESIS
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("more items in flight than result slots");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        EW_W'(col_reg) < eff_w)
        else $error("column position outside the frame");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= eff_w)
        else $error("pending drain count exceeds the row width");

    a_drain_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_pixel) |=> !ram_we)
        else $error("drain beat wrote the line store");
`endif

endmodule
